// ===== rtl/orbit_camera_basis_macros.svh =====
// assertion macros shared by the orbit camera rtl
`ifndef ORBIT_CAMERA_BASIS_MACROS_SVH
`define ORBIT_CAMERA_BASIS_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define ORBC_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("orbc: assertion failed");

// antecedent implies consequent in the next cycle
`define ORBC_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("orbc: assertion failed");

// condition never holds
`define ORBC_ASSERT_NEVER(lbl, ck, rn, cond) \
  lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) \
    else $error("orbc: assertion failed");

`else

`define ORBC_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define ORBC_ASSERT_NXT(lbl, ck, rn, ante, cons)
`define ORBC_ASSERT_NEVER(lbl, ck, rn, cond)

`endif

`endif

// ===== rtl/orbc_pkg.sv =====
`default_nettype none

package orbc_pkg;

  // default trig table precision
  localparam int TrigFracBitsDef = 14;

  // angle limits in degrees
  localparam int HorizLimit = 89;
  localparam int StepLimit  = 359;
  localparam int DegQuarter = 90;
  localparam int DegHalf    = 180;
  localparam int DegThree   = 270;
  localparam int DegFull    = 360;

  // configuration register indexes
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgRadius     = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgStartHoriz = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgStartVert  = 2'd2;

  localparam logic [15:0] RadiusRst     = 16'd1280;
  localparam logic signed [7:0] StartHorizRst = 8'sd0;
  localparam logic [8:0] StartVertRst  = 9'd0;

  // queue between front and back
  localparam int QDepth = 2;

  // sine of whole degrees 0..90, scaled by 1e10
  localparam int TrigEntries = 91;
  localparam logic [63:0] DecOne  = 64'd10000000000;
  localparam logic [63:0] DecHalf = 64'd5000000000;
  localparam logic [63:0] SinDec [TrigEntries] = '{
    64'd0, 64'd174524064, 64'd348994967, 64'd523359562, 64'd697564737,
    64'd871557427, 64'd1045284633, 64'd1218693434, 64'd1391731010, 64'd1564344650,
    64'd1736481777, 64'd1908089954, 64'd2079116908, 64'd2249510543, 64'd2419218956,
    64'd2588190451, 64'd2756373558, 64'd2923717047, 64'd3090169944, 64'd3255681545,
    64'd3420201433, 64'd3583679495, 64'd3746065934, 64'd3907311285, 64'd4067366431,
    64'd4226182617, 64'd4383711468, 64'd4539904997, 64'd4694715628, 64'd4848096202,
    64'd5000000000, 64'd5150380749, 64'd5299192642, 64'd5446390350, 64'd5591929035,
    64'd5735764364, 64'd5877852523, 64'd6018150232, 64'd6156614753, 64'd6293203910,
    64'd6427876097, 64'd6560590290, 64'd6691306064, 64'd6819983601, 64'd6946583705,
    64'd7071067812, 64'd7193398003, 64'd7313537016, 64'd7431448255, 64'd7547095802,
    64'd7660444431, 64'd7771459615, 64'd7880107536, 64'd7986355100, 64'd8090169944,
    64'd8191520443, 64'd8290375726, 64'd8386705679, 64'd8480480962, 64'd8571673007,
    64'd8660254038, 64'd8746197071, 64'd8829475929, 64'd8910065242, 64'd8987940463,
    64'd9063077870, 64'd9135454576, 64'd9205048535, 64'd9271838546, 64'd9335804265,
    64'd9396926208, 64'd9455185756, 64'd9510565163, 64'd9563047560, 64'd9612616959,
    64'd9659258263, 64'd9702957263, 64'd9743700648, 64'd9781476007, 64'd9816271834,
    64'd9848077530, 64'd9876883406, 64'd9902680687, 64'd9925461516, 64'd9945218954,
    64'd9961946981, 64'd9975640503, 64'd9986295348, 64'd9993908270, 64'd9998476952,
    64'd10000000000
  };

  // angles after one step, as carried from front to back
  typedef struct packed {
    logic signed [7:0] horiz;
    logic [8:0]        vert;
  } orbc_angles_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } orbc_qstat_t;

  // angle folded into the first quadrant
  typedef struct packed {
    logic       neg;
    logic [6:0] idx;
  } orbc_fold_t;

  // fold an angle of 0..359 degrees onto the quarter table
  function automatic orbc_fold_t trig_fold(input logic [8:0] d);
    orbc_fold_t f;
    if (d <= 9'(DegQuarter)) begin
      f.neg = 1'b0;
      f.idx = 7'(d);
    end else if (d <= 9'(DegHalf)) begin
      f.neg = 1'b0;
      f.idx = 7'(9'(DegHalf) - d);
    end else if (d <= 9'(DegThree)) begin
      f.neg = 1'b1;
      f.idx = 7'(d - 9'(DegHalf));
    end else begin
      f.neg = 1'b1;
      f.idx = 7'(9'(DegFull) - d);
    end
    return f;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/orbit_camera_basis.sv =====
// orbit camera basis: integer-degree orbit camera around the origin
//
// input channel (in_valid / in_stall): one transaction is one camera step,
//   either a restart from the start registers or a pair of angle deltas.
// output channel (out_valid / out_stall): one transaction per step with the
//   new angles, the position, the horizontal right vector and the up vector.
// config channel (cfg_valid / cfg_ready, always ready): cfg_index selects
//   radius, start horizontal or start vertical; cfg_data holds the value.
//
// a front stage updates the angles and pushes them into a two-entry queue;
// a back sequencer runs table lookup, two multiply passes, rounding and the
// up-vector products. the back sequencer takes one step at a time through
// its states (multiply, multiply, round, up products) and pops the next step
// from the queue as it loads a result into the output register.
// when the receiver stalls, the result stays in the output register, the back
// sequencer waits in its last step and the front keeps taking steps until the
// queue is full, then raises in_stall.
// reset (rst_n low at a clock edge) clears both angles and the queue, sets
// radius to 1280 and both start registers to zero.
`default_nettype none

module orbit_camera_basis
  import orbc_pkg::*;
#(
  parameter int TRIG_FRACTION_BITS = TrigFracBitsDef
) (
  input  wire logic                clk,
  input  wire logic                rst_n,

  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                in_restart,
  input  wire logic signed [9:0]   in_horizontal_step,
  input  wire logic signed [9:0]   in_vertical_step,

  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic signed [7:0]        out_horizontal_now,
  output logic [8:0]               out_vertical_now,
  output logic signed [16:0]       out_pos_x,
  output logic signed [16:0]       out_pos_y,
  output logic signed [16:0]       out_pos_z,
  output logic signed [16:0]       out_right_x,
  output logic signed [16:0]       out_right_z,
  output logic signed [32:0]       out_up_x,
  output logic [32:0]              out_up_y,
  output logic signed [32:0]       out_up_z,

  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [15:0]         cfg_data
);

  // configuration registers
  logic [15:0]        radius_r;
  logic signed [7:0]  start_horiz_r;
  logic [8:0]         start_vert_r;

  // front to queue and queue to back
  logic               push;
  orbc_angles_t       push_data;
  logic               pop;
  orbc_angles_t       q_head;
  orbc_qstat_t        q_stat;

  // writes are taken in any cycle; index beyond the list is dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r      <= RadiusRst;
      start_horiz_r <= StartHorizRst;
      start_vert_r  <= StartVertRst;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CfgRadius:     radius_r      <= cfg_data;
        CfgStartHoriz: start_horiz_r <= $signed(cfg_data[7:0]);
        CfgStartVert:  start_vert_r  <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // front: handshake, restart or delta, angle state
  orbc_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_restart         (in_restart),
    .in_horizontal_step (in_horizontal_step),
    .in_vertical_step   (in_vertical_step),
    .start_horiz        (start_horiz_r),
    .start_vert         (start_vert_r),
    .q_stat             (q_stat),
    .push               (push),
    .push_data          (push_data)
  );

  // decouples the front from the back sequencer
  orbc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  // back: trig lookup, position, right and up vectors, output register
  orbc_back #(
    .TRIG_FRACTION_BITS (TRIG_FRACTION_BITS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_stat             (q_stat),
    .q_head             (q_head),
    .pop                (pop),
    .radius             (radius_r),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_horizontal_now (out_horizontal_now),
    .out_vertical_now   (out_vertical_now),
    .out_pos_x          (out_pos_x),
    .out_pos_y          (out_pos_y),
    .out_pos_z          (out_pos_z),
    .out_right_x        (out_right_x),
    .out_right_z        (out_right_z),
    .out_up_x           (out_up_x),
    .out_up_y           (out_up_y),
    .out_up_z           (out_up_z)
  );

endmodule

`default_nettype wire

// ===== rtl/orbc_queue.sv =====
`default_nettype none

`include "orbit_camera_basis_macros.svh"

module orbc_queue
  import orbc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire orbc_angles_t push_data,
  input  wire logic         pop,
  output orbc_angles_t      head,
  output orbc_qstat_t       stat
);

  localparam int PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int CntW = $clog2(QDepth + 1);

  orbc_angles_t          entries_r [QDepth];
  logic [PtrW-1:0]       wr_ptr_r;
  logic [PtrW-1:0]       rd_ptr_r;
  logic [CntW-1:0]       count_r;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(QDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign head       = entries_r[rd_ptr_r];
  assign stat.full  = (count_r == CntW'(QDepth));
  assign stat.empty = (count_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        entries_r[wr_ptr_r] <= push_data;
        wr_ptr_r            <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  `ORBC_ASSERT_NEVER(a_push_full, clk, rst_n, push && stat.full)
  `ORBC_ASSERT_NEVER(a_pop_empty, clk, rst_n, pop && stat.empty)
  `ORBC_ASSERT_NXT(a_cnt_up, clk, rst_n, push && !pop, count_r == $past(count_r) + 1'b1)

endmodule

`default_nettype wire

// ===== rtl/orbc_front.sv =====
`default_nettype none

module orbc_front
  import orbc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_restart,
  input  wire logic signed [9:0] in_horizontal_step,
  input  wire logic signed [9:0] in_vertical_step,
  input  wire logic signed [7:0] start_horiz,
  input  wire logic [8:0]        start_vert,
  input  wire orbc_qstat_t       q_stat,
  output logic                   push,
  output orbc_angles_t           push_data
);

  localparam logic signed [9:0]  StepHi = 10'(StepLimit);
  localparam logic signed [9:0]  StepLo = -10'(StepLimit);
  localparam logic signed [10:0] HLimHi = 11'(HorizLimit);
  localparam logic signed [10:0] HLimLo = -11'(HorizLimit);
  localparam logic signed [10:0] VFull  = 11'(DegFull);

  logic signed [7:0]  horiz_r, horiz_nxt;
  logic [8:0]         vert_r, vert_nxt;
  logic signed [9:0]  dh, dv;
  logic signed [10:0] h_sum, v_sum;
  logic               accept;

  function automatic logic signed [9:0] sat_step(input logic signed [9:0] a);
    if (a > StepHi) begin
      return StepHi;
    end else if (a < StepLo) begin
      return StepLo;
    end
    return a;
  endfunction

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;

  assign dh    = sat_step(in_horizontal_step);
  assign dv    = sat_step(in_vertical_step);
  assign h_sum = 11'(horiz_r) + 11'(dh);
  assign v_sum = $signed({2'b00, vert_r}) + 11'(dv);

  always_comb begin
    horiz_nxt = horiz_r;
    vert_nxt  = vert_r;
    if (in_restart) begin
      // reload from config, clamped and folded
      if (11'(start_horiz) > HLimHi) begin
        horiz_nxt = 8'(HLimHi);
      end else if (11'(start_horiz) < HLimLo) begin
        horiz_nxt = 8'(HLimLo);
      end else begin
        horiz_nxt = start_horiz;
      end
      vert_nxt = (start_vert >= 9'(DegFull)) ? 9'(start_vert - 9'(DegFull)) : start_vert;
    end else begin
      // horizontal move is dropped when it leaves the limit
      if (h_sum <= HLimHi && h_sum >= HLimLo) begin
        horiz_nxt = 8'(h_sum);
      end
      if (v_sum <= 11'sd0) begin
        vert_nxt = 9'(v_sum + VFull);
      end else if (v_sum >= VFull) begin
        vert_nxt = 9'(v_sum - VFull);
      end else begin
        vert_nxt = 9'(v_sum);
      end
    end
  end

  assign push            = accept;
  assign push_data.horiz = horiz_nxt;
  assign push_data.vert  = vert_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      horiz_r <= StartHorizRst;
      vert_r  <= StartVertRst;
    end else if (accept) begin
      horiz_r <= horiz_nxt;
      vert_r  <= vert_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/orbc_back.sv =====
`default_nettype none

`include "orbit_camera_basis_macros.svh"

module orbc_back
  import orbc_pkg::*;
#(
  parameter int TRIG_FRACTION_BITS = TrigFracBitsDef
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire orbc_qstat_t        q_stat,
  input  wire orbc_angles_t       q_head,
  output logic                    pop,
  input  wire logic [15:0]        radius,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [7:0]       out_horizontal_now,
  output logic [8:0]              out_vertical_now,
  output logic signed [16:0]      out_pos_x,
  output logic signed [16:0]      out_pos_y,
  output logic signed [16:0]      out_pos_z,
  output logic signed [16:0]      out_right_x,
  output logic signed [16:0]      out_right_z,
  output logic signed [32:0]      out_up_x,
  output logic [32:0]             out_up_y,
  output logic signed [32:0]      out_up_z
);

  localparam int QW  = TRIG_FRACTION_BITS + 1;
  localparam int P1W = 16 + QW;
  localparam int P2W = P1W + QW;

  typedef logic [QW-1:0] qtab_t [TrigEntries];

  function automatic qtab_t build_qtab();
    qtab_t tab;
    for (int k = 0; k < TrigEntries; k++) begin
      tab[k] = QW'(((SinDec[k] << TRIG_FRACTION_BITS) + DecHalf) / DecOne);
    end
    return tab;
  endfunction

  localparam qtab_t QTab = build_qtab();

  localparam logic [P1W-1:0] Half1 = P1W'(1) << (TRIG_FRACTION_BITS - 1);
  localparam logic [P2W-1:0] Half2 = P2W'(1) << (2 * TRIG_FRACTION_BITS - 1);

  function automatic logic [QW-1:0] qlook(input logic [6:0] idx);
    return (idx <= 7'(DegQuarter)) ? QTab[idx] : '0;
  endfunction

  function automatic logic signed [16:0] apply_sign(input logic neg, input logic [16:0] mag);
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_RND,
    S_UP
  } state_t;

  state_t state_r, state_nxt;

  // angles of the item in flight
  logic signed [7:0] h_r;
  logic [8:0]        v_r;
  logic [QW-1:0]     mag_sh_r, mag_ch_r, mag_sv_r, mag_cv_r;
  logic              neg_sh_r, neg_ch_r, neg_sv_r, neg_cv_r;

  // products and rounded position
  logic [P1W-1:0]     rsv_r, rch_r, rsh_r;
  logic [P2W-1:0]     pxp_r, pzp_r;
  logic signed [16:0] py_r, px_r, pz_r;

  logic               out_valid_r;
  logic               out_free, out_load;

  // lookup of the queue head
  logic signed [9:0]  h_ext;
  logic [9:0]         v_cos_sum;
  logic [8:0]         h_sin_d, h_cos_d, v_sin_d, v_cos_d;
  orbc_fold_t         f_sh, f_ch, f_sv, f_cv;

  logic [P1W-1:0]     py_sum;
  logic [P2W-1:0]     px_sum, pz_sum;
  logic signed [33:0] m_xy, m_yz, m_xx, m_zz, sq_sum;

  assign h_ext     = 10'(q_head.horiz);
  assign h_sin_d   = (h_ext < 10'sd0) ? 9'(h_ext + 10'sd360) : 9'(h_ext);
  assign h_cos_d   = 9'(h_ext + 10'sd90);
  assign v_sin_d   = (q_head.vert == 9'(DegFull)) ? 9'd0 : q_head.vert;
  assign v_cos_sum = {1'b0, q_head.vert} + 10'(DegQuarter);
  assign v_cos_d   = (v_cos_sum >= 10'(DegFull)) ? 9'(v_cos_sum - 10'(DegFull))
                                                 : 9'(v_cos_sum);

  assign f_sh = trig_fold(h_sin_d);
  assign f_ch = trig_fold(h_cos_d);
  assign f_sv = trig_fold(v_sin_d);
  assign f_cv = trig_fold(v_cos_d);

  // round to nearest, ties away from zero, on magnitudes
  assign py_sum = rsh_r + Half1;
  assign px_sum = pxp_r + Half2;
  assign pz_sum = pzp_r + Half2;

  // up vector products
  assign m_xy   = 34'(px_r) * 34'(py_r);
  assign m_yz   = 34'(py_r) * 34'(pz_r);
  assign m_xx   = 34'(px_r) * 34'(px_r);
  assign m_zz   = 34'(pz_r) * 34'(pz_r);
  assign sq_sum = m_xx + m_zz;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (!q_stat.empty) begin
          pop       = 1'b1;
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_RND;
      S_RND:  state_nxt = S_UP;
      S_UP: begin
        if (out_free) begin
          out_load = 1'b1;
          if (!q_stat.empty) begin
            pop       = 1'b1;
            state_nxt = S_MUL1;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_load || (out_valid_r && out_stall);

      if (pop) begin
        h_r      <= q_head.horiz;
        v_r      <= q_head.vert;
        mag_sh_r <= qlook(f_sh.idx);
        mag_ch_r <= qlook(f_ch.idx);
        mag_sv_r <= qlook(f_sv.idx);
        mag_cv_r <= qlook(f_cv.idx);
        neg_sh_r <= f_sh.neg;
        neg_ch_r <= f_ch.neg;
        neg_sv_r <= f_sv.neg;
        neg_cv_r <= f_cv.neg;
      end

      if (state_r == S_MUL1) begin
        rsv_r <= P1W'(radius) * P1W'(mag_sv_r);
        rch_r <= P1W'(radius) * P1W'(mag_ch_r);
        rsh_r <= P1W'(radius) * P1W'(mag_sh_r);
      end

      if (state_r == S_MUL2) begin
        pxp_r <= P2W'(rsv_r) * P2W'(mag_ch_r);
        pzp_r <= P2W'(rch_r) * P2W'(mag_cv_r);
        py_r  <= apply_sign(neg_sh_r, py_sum[TRIG_FRACTION_BITS +: 17]);
      end

      if (state_r == S_RND) begin
        px_r <= apply_sign(neg_sv_r ^ neg_ch_r, px_sum[2 * TRIG_FRACTION_BITS +: 17]);
        pz_r <= apply_sign(neg_ch_r ^ neg_cv_r, pz_sum[2 * TRIG_FRACTION_BITS +: 17]);
      end

      if (out_load) begin
        out_horizontal_now <= h_r;
        out_vertical_now   <= v_r;
        out_pos_x          <= px_r;
        out_pos_y          <= py_r;
        out_pos_z          <= pz_r;
        out_right_x        <= -pz_r;
        out_right_z        <= px_r;
        out_up_x           <= 33'(-m_xy);
        out_up_y           <= sq_sum[32:0];
        out_up_z           <= 33'(-m_yz);
      end
    end
  end

  assign out_valid = out_valid_r;

  `ORBC_ASSERT_IMP(a_pop_state, clk, rst_n, pop, (state_r == S_IDLE || state_r == S_UP))
  `ORBC_ASSERT_NXT(a_pop_mul, clk, rst_n, pop, state_r == S_MUL1)
  `ORBC_ASSERT_IMP(a_out_rise, clk, rst_n, $rose(out_valid_r), $past(state_r) == S_UP)

endmodule

`default_nettype wire

// ===== bench/orbit_camera_basis_tb.sv =====
`timescale 1ns / 100ps

module orbit_camera_basis_tb;
  import orbc_pkg::CfgIdxW;
  import orbc_pkg::CfgRadius;
  import orbc_pkg::CfgStartHoriz;
  import orbc_pkg::CfgStartVert;

  // index past the end of the register list, must be ignored
  localparam logic [CfgIdxW-1:0] CfgNoReg = 2'd3;

  localparam int TRIG_BITS  = 14;
  localparam int H_LIMIT    = 89;
  localparam int STEP_MAX   = 359;
  localparam int FULL_TURN  = 360;
  localparam int DRAIN_GAP  = 12;       // extra wait after the last expected result
  localparam int CYCLE_CAP  = 500000;   // generous run limit
  localparam int PHASES     = 6;
  localparam int PHASE_LEN  = 215;

  localparam longint unsigned DEC_ONE  = 64'd10000000000;
  localparam longint unsigned DEC_HALF = 64'd5000000000;

  // sine of whole degrees 0..90, scaled by 1e10
  localparam bit [63:0] SINE_E10 [0:90] = '{
    64'd0, 64'd174524064, 64'd348994967, 64'd523359562, 64'd697564737,
    64'd871557427, 64'd1045284633, 64'd1218693434, 64'd1391731010, 64'd1564344650,
    64'd1736481777, 64'd1908089954, 64'd2079116908, 64'd2249510543, 64'd2419218956,
    64'd2588190451, 64'd2756373558, 64'd2923717047, 64'd3090169944, 64'd3255681545,
    64'd3420201433, 64'd3583679495, 64'd3746065934, 64'd3907311285, 64'd4067366431,
    64'd4226182617, 64'd4383711468, 64'd4539904997, 64'd4694715628, 64'd4848096202,
    64'd5000000000, 64'd5150380749, 64'd5299192642, 64'd5446390350, 64'd5591929035,
    64'd5735764364, 64'd5877852523, 64'd6018150232, 64'd6156614753, 64'd6293203910,
    64'd6427876097, 64'd6560590290, 64'd6691306064, 64'd6819983601, 64'd6946583705,
    64'd7071067812, 64'd7193398003, 64'd7313537016, 64'd7431448255, 64'd7547095802,
    64'd7660444431, 64'd7771459615, 64'd7880107536, 64'd7986355100, 64'd8090169944,
    64'd8191520443, 64'd8290375726, 64'd8386705679, 64'd8480480962, 64'd8571673007,
    64'd8660254038, 64'd8746197071, 64'd8829475929, 64'd8910065242, 64'd8987940463,
    64'd9063077870, 64'd9135454576, 64'd9205048535, 64'd9271838546, 64'd9335804265,
    64'd9396926208, 64'd9455185756, 64'd9510565163, 64'd9563047560, 64'd9612616959,
    64'd9659258263, 64'd9702957263, 64'd9743700648, 64'd9781476007, 64'd9816271834,
    64'd9848077530, 64'd9876883406, 64'd9902680687, 64'd9925461516, 64'd9945218954,
    64'd9961946981, 64'd9975640503, 64'd9986295348, 64'd9993908270, 64'd9998476952,
    64'd10000000000
  };

  // one camera basis as it leaves the block, at port widths
  typedef struct packed {
    logic [7:0]  horiz;
    logic [8:0]  vert;
    logic [16:0] pos_x;
    logic [16:0] pos_y;
    logic [16:0] pos_z;
    logic [16:0] right_x;
    logic [16:0] right_z;
    logic [32:0] up_x;
    logic [32:0] up_y;
    logic [32:0] up_z;
  } basis_t;

  logic clk;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_restart = 1'b0;
  logic signed [9:0]  in_horizontal_step = '0;
  logic signed [9:0]  in_vertical_step = '0;

  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [7:0]  out_horizontal_now;
  logic [8:0]         out_vertical_now;
  logic signed [16:0] out_pos_x;
  logic signed [16:0] out_pos_y;
  logic signed [16:0] out_pos_z;
  logic signed [16:0] out_right_x;
  logic signed [16:0] out_right_z;
  logic signed [32:0] out_up_x;
  logic [32:0]        out_up_y;
  logic signed [32:0] out_up_z;

  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [15:0]        cfg_data = '0;

  // shadow of the config registers and the camera angles
  int radius_reg;
  int start_h_reg;
  int start_v_reg;
  int cam_h;
  int cam_v;

  basis_t pending_basis[$];   // expected results, oldest first
  int     mismatches;
  int     cycles;
  int     stall_left;
  bit     no_idle;            // when set neither side idles

  orbit_camera_basis u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_restart         (in_restart),
    .in_horizontal_step (in_horizontal_step),
    .in_vertical_step   (in_vertical_step),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_horizontal_now (out_horizontal_now),
    .out_vertical_now   (out_vertical_now),
    .out_pos_x          (out_pos_x),
    .out_pos_y          (out_pos_y),
    .out_pos_z          (out_pos_z),
    .out_right_x        (out_right_x),
    .out_right_z        (out_right_z),
    .out_up_x           (out_up_x),
    .out_up_y           (out_up_y),
    .out_up_z           (out_up_z),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_CAP) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // camera predictor
  // ---------------------------------------------------------------------------

  // first quadrant sine in q1.14, rounded half up from the decimal table
  function automatic longint quarter_sine(input int deg);
    longint unsigned s;
    s = SINE_E10[deg];
    return longint'(((s << TRIG_BITS) + DEC_HALF) / DEC_ONE);
  endfunction

  // sine of any whole degree, folded by quadrant
  function automatic longint sine_deg(input int deg);
    int a;
    a = ((deg % FULL_TURN) + FULL_TURN) % FULL_TURN;
    if (a <= 90) return quarter_sine(a);
    else if (a <= 180) return quarter_sine(180 - a);
    else if (a <= 270) return -quarter_sine(a - 180);
    else return -quarter_sine(FULL_TURN - a);
  endfunction

  // shift right, round to nearest, ties away from zero
  function automatic longint round_away(input longint v, input int sh);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (longint'(1) << (sh - 1))) >>> sh;
    return (v < 0) ? -m : m;
  endfunction

  function automatic int clamp_step(input logic [9:0] raw);
    int d;
    d = int'($signed(raw));
    if (d > STEP_MAX) return STEP_MAX;
    if (d < -STEP_MAX) return -STEP_MAX;
    return d;
  endfunction

  // advance the camera angles by one step and build the expected basis
  function automatic basis_t step_camera(input bit restart, input logic [9:0] dh_raw,
                                         input logic [9:0] dv_raw);
    int     hs;
    int     vs;
    longint r;
    longint sh;
    longint ch;
    longint sv;
    longint cv;
    longint px;
    longint py;
    longint pz;
    basis_t b;
    if (restart) begin
      // start horizontal saturates to the limit, start vertical folds once
      hs = start_h_reg;
      if (hs > H_LIMIT) hs = H_LIMIT;
      if (hs < -H_LIMIT) hs = -H_LIMIT;
      cam_h = hs;
      cam_v = (start_v_reg >= FULL_TURN) ? start_v_reg - FULL_TURN : start_v_reg;
    end else begin
      hs = cam_h + clamp_step(dh_raw);
      vs = cam_v + clamp_step(dv_raw);
      // horizontal change past the limit is dropped
      if (hs <= H_LIMIT && hs >= -H_LIMIT) cam_h = hs;
      // vertical wraps, zero reads as a full turn
      if (vs <= 0) vs += FULL_TURN;
      else if (vs >= FULL_TURN) vs -= FULL_TURN;
      cam_v = vs;
    end
    r  = longint'(radius_reg);
    sh = sine_deg(cam_h);
    ch = sine_deg(cam_h + 90);
    sv = sine_deg(cam_v);
    cv = sine_deg(cam_v + 90);
    px = round_away(r * sv * ch, 2 * TRIG_BITS);
    py = round_away(r * sh, TRIG_BITS);
    pz = round_away(r * ch * cv, 2 * TRIG_BITS);
    b.horiz   = 8'(cam_h);
    b.vert    = 9'(cam_v);
    b.pos_x   = 17'(px);
    b.pos_y   = 17'(py);
    b.pos_z   = 17'(pz);
    b.right_x = 17'(-pz);
    b.right_z = 17'(px);
    b.up_x    = 33'(-(px * py));
    b.up_y    = 33'(px * px + pz * pz);
    b.up_z    = 33'(-(py * pz));
    return b;
  endfunction

  // ---------------------------------------------------------------------------
  // idle draw shared by sender and receiver
  // ---------------------------------------------------------------------------
  function automatic int idle_cycles();
    if (no_idle) return 0;
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 15);
  endfunction

  // ---------------------------------------------------------------------------
  // result checker: takes each output transaction and compares it with the
  // oldest expected basis; out_stall is redrawn after every transaction
  // ---------------------------------------------------------------------------
  initial begin
    mismatches = 0;
    stall_left = 0;
  end

  always @(posedge clk) begin
    basis_t got;
    basis_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      got = '{out_horizontal_now, out_vertical_now, out_pos_x, out_pos_y, out_pos_z,
              out_right_x, out_right_z, out_up_x, out_up_y, out_up_z};
      if (pending_basis.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result at cycle %0d: horiz %0d vert %0d",
                   cycles, $signed(got.horiz), got.vert);
      end else begin
        want = pending_basis.pop_front();
        if (got.horiz !== want.horiz || got.vert !== want.vert ||
            got.pos_x !== want.pos_x || got.pos_y !== want.pos_y ||
            got.pos_z !== want.pos_z || got.right_x !== want.right_x ||
            got.right_z !== want.right_z || got.up_x !== want.up_x ||
            got.up_y !== want.up_y || got.up_z !== want.up_z) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at cycle %0d (expected/actual): horiz %0d/%0d vert %0d/%0d",
                     cycles, $signed(want.horiz), $signed(got.horiz), want.vert, got.vert);
            $display("  pos %0d,%0d,%0d / %0d,%0d,%0d  right %0d,%0d / %0d,%0d",
                     $signed(want.pos_x), $signed(want.pos_y), $signed(want.pos_z),
                     $signed(got.pos_x), $signed(got.pos_y), $signed(got.pos_z),
                     $signed(want.right_x), $signed(want.right_z),
                     $signed(got.right_x), $signed(got.right_z));
            $display("  up %0d,%0d,%0d / %0d,%0d,%0d",
                     $signed(want.up_x), want.up_y, $signed(want.up_z),
                     $signed(got.up_x), got.up_y, $signed(got.up_z));
          end
        end
      end
      stall_left = idle_cycles();
    end else if (stall_left > 0) begin
      stall_left--;
    end
    out_stall <= (stall_left > 0);
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // one input transaction; valid stays high into the next step unless a gap
  // is drawn, so back-to-back items never lower and raise valid in one step
  task automatic send_step(input bit restart, input logic [9:0] dh, input logic [9:0] dv);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_restart         <= restart;
    in_horizontal_step <= dh;
    in_vertical_step   <= dv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // accepted at this edge
    pending_basis.push_back(step_camera(restart, dh, dv));
  endtask

  // sender pauses until every expected result is back, then waits out DRAIN_GAP
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_basis.size() > 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  // config transaction, only while the block is idle
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] val);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CfgRadius:     radius_reg  = int'(val);
      CfgStartHoriz: start_h_reg = int'($signed(val[7:0]));
      CfgStartVert:  start_v_reg = int'(val[8:0]);
      default: ;
    endcase
  endtask

  // mostly well-formed walks, some full-range and raw noise, rare restarts
  task automatic send_random_step();
    int pick;
    logic [9:0] dh;
    logic [9:0] dv;
    pick = $urandom_range(0, 99);
    if (pick < 76) begin
      dh = 10'($urandom_range(0, 40) - 20);
      dv = 10'($urandom_range(0, 2 * STEP_MAX) - STEP_MAX);
    end else if (pick < 88) begin
      dh = 10'($urandom_range(0, 2 * STEP_MAX) - STEP_MAX);
      dv = 10'($urandom_range(0, 2 * STEP_MAX) - STEP_MAX);
    end else begin
      dh = 10'($urandom);
      dv = 10'($urandom);
    end
    send_step(pick % 16 == 5, dh, dv);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // angle arithmetic corners at the reset configuration
  task automatic test_angle_corners();
    send_step(1'b0, 10'sd0, 10'sd0);       // zero vertical reads as full turn
    send_step(1'b0, 10'sd89, 10'sd1);      // horizontal right at the limit
    send_step(1'b0, 10'sd1, 10'sd359);     // horizontal dropped, vertical wraps to 0
    send_step(1'b0, -10'sd178, -10'sd359); // down to the lower limit, vertical wraps up
    send_step(1'b0, -10'sd1, 10'sd0);      // below lower limit, dropped
    send_step(1'b0, 10'sd511, 10'sd511);   // deltas saturate
    send_step(1'b0, -10'sd512, -10'sd512);
    send_step(1'b0, 10'sd360, -10'sd360);
    send_step(1'b0, -10'sd1, 10'sd1);
    send_step(1'b1, 10'sd511, -10'sd512);  // restart ignores the deltas
    send_step(1'b0, 10'sd45, 10'sd90);     // walk through every quadrant
    send_step(1'b0, 10'sd0, 10'sd90);
    send_step(1'b0, -10'sd90, 10'sd90);
    send_step(1'b0, 10'sd0, 10'sd90);
  endtask

  // register extremes, checked through restarts; the off-list write through a plain step
  task automatic test_register_extremes();
    write_reg(CfgRadius, 16'hFFFF);
    write_reg(CfgStartHoriz, 16'd89);
    write_reg(CfgStartVert, 16'd359);
    send_step(1'b1, 10'sd0, 10'sd0);
    send_step(1'b0, 10'sd0, 10'sd46);
    write_reg(CfgStartHoriz, 16'h007F);    // beyond the limit, saturates on restart
    write_reg(CfgStartVert, 16'd511);      // 360 or more folds once
    send_step(1'b1, 10'sd3, 10'sd3);
    write_reg(CfgStartHoriz, 16'hFF80);
    write_reg(CfgStartVert, 16'd360);
    send_step(1'b1, 10'sd0, 10'sd0);
    write_reg(CfgStartHoriz, 16'd90);
    send_step(1'b1, 10'sd0, 10'sd0);
    write_reg(CfgStartHoriz, 16'hABA6);    // -90 in the low byte, upper bits ignored
    write_reg(CfgRadius, 16'd0);
    send_step(1'b1, 10'sd0, 10'sd0);
    write_reg(CfgNoReg, 16'h1234);         // index off the list leaves all as is
    send_step(1'b0, 10'sd7, -10'sd7);
  endtask

  // long random walks over several register settings
  task automatic test_random_walk();
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       write_reg(CfgRadius, 16'hFFFF);
        1:       write_reg(CfgRadius, 16'd1);
        default: write_reg(CfgRadius, 16'($urandom));
      endcase
      write_reg(CfgStartHoriz, 16'($urandom));
      write_reg(CfgStartVert, 16'($urandom));
      send_step(1'b1, 10'($urandom), 10'($urandom));
      for (int i = 0; i < PHASE_LEN; i++) begin
        if (i % 40 == 0) no_idle = ($urandom_range(0, 2) == 0);
        // sender holds off once per phase until the pipe is empty
        if (i == 100) drain_results();
        send_random_step();
      end
      no_idle = 1'b0;
    end
  endtask

  initial begin
    radius_reg  = 1280;
    start_h_reg = 0;
    start_v_reg = 0;
    cam_h       = 0;
    cam_v       = 0;
    no_idle     = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_angle_corners();
    test_register_extremes();
    test_random_walk();

    drain_results();
    if (mismatches == 0 && pending_basis.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
